FILE: rtl/sli_pkg.sv
`default_nettype none
package sli_pkg;
   localparam int CoordWidth = 16;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int CrossWidth = ProdWidth + 1;
   localparam int DenWidth   = CrossWidth + 1;
   localparam int MagWidth   = DenWidth - 1;
   localparam int NumWidth   = DiffWidth + MagWidth;
   localparam int QuoWidth   = DiffWidth;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;

   typedef struct packed {
      logic                     valid;
      logic                     hit;
      coord_type                sx;
      coord_type                sy;
      logic                     negx;
      logic                     negy;
      logic [NumWidth-1:0]      numx;
      logic [NumWidth-1:0]      numy;
      logic [MagWidth-1:0]      den;
   } div_in_type;
endpackage
`default_nettype wire

FILE: rtl/sli_front.sv
`default_nettype none
module sli_front import sli_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire coord_type sx, input wire coord_type sy,
   input  wire coord_type ex, input wire coord_type ey,
   input  wire coord_type ax, input wire coord_type ay,
   input  wire coord_type bx, input wire coord_type by,
   output div_in_type     out
);
   // Stage 1: differences.
   logic v1_ff;
   diff_type dx_ff, dy_ff, vsx_ff, vsy_ff, vex_ff, vey_ff, ddx_ff, ddy_ff;
   coord_type sx1_ff, sy1_ff;
   // Stage 2: products.
   logic v2_ff;
   logic signed [ProdWidth-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   diff_type ddx2_ff, ddy2_ff;
   coord_type sx2_ff, sy2_ff;
   // Stage 3: cross products.
   logic v3_ff;
   logic signed [CrossWidth-1:0] cs_ff, ce_ff;
   diff_type ddx3_ff, ddy3_ff;
   coord_type sx3_ff, sy3_ff;
   // Stage 4: magnitudes.
   logic v4_ff, hit4_ff, sneg4_ff;
   logic [MagWidth-1:0] csm_ff, denm_ff;
   logic [DiffWidth-1:0] mx_ff, my_ff;
   logic nx_ff, ny_ff;
   coord_type sx4_ff, sy4_ff;
   // Stage 5: numerators.
   div_in_type o_ff;

   logic signed [DenWidth-1:0] den_w;
   logic hit_w;
   logic [DenWidth-1:0] csa_w, dena_w;

   always_comb begin
      den_w  = DenWidth'(cs_ff) - DenWidth'(ce_ff);
      hit_w  = (den_w != '0) &&
               ((cs_ff == '0) || (ce_ff == '0) || (cs_ff[CrossWidth-1] != ce_ff[CrossWidth-1]));
      csa_w  = cs_ff[CrossWidth-1] ? DenWidth'(-DenWidth'(cs_ff)) : DenWidth'(cs_ff);
      dena_w = den_w[DenWidth-1] ? DenWidth'(-den_w) : DenWidth'(den_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         o_ff.valid <= 1'b0;
      end else begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         o_ff.valid <= v4_ff;
      end
      dx_ff  <= DiffWidth'(bx) - DiffWidth'(ax);
      dy_ff  <= DiffWidth'(by) - DiffWidth'(ay);
      vsx_ff <= DiffWidth'(sx) - DiffWidth'(ax);
      vsy_ff <= DiffWidth'(sy) - DiffWidth'(ay);
      vex_ff <= DiffWidth'(ex) - DiffWidth'(ax);
      vey_ff <= DiffWidth'(ey) - DiffWidth'(ay);
      ddx_ff <= DiffWidth'(ex) - DiffWidth'(sx);
      ddy_ff <= DiffWidth'(ey) - DiffWidth'(sy);
      sx1_ff <= sx; sy1_ff <= sy;

      p0_ff <= dx_ff * vsy_ff;
      p1_ff <= dy_ff * vsx_ff;
      p2_ff <= dx_ff * vey_ff;
      p3_ff <= dy_ff * vex_ff;
      ddx2_ff <= ddx_ff; ddy2_ff <= ddy_ff; sx2_ff <= sx1_ff; sy2_ff <= sy1_ff;

      cs_ff <= CrossWidth'(p0_ff) - CrossWidth'(p1_ff);
      ce_ff <= CrossWidth'(p2_ff) - CrossWidth'(p3_ff);
      ddx3_ff <= ddx2_ff; ddy3_ff <= ddy2_ff; sx3_ff <= sx2_ff; sy3_ff <= sy2_ff;

      hit4_ff  <= hit_w;
      sneg4_ff <= cs_ff[CrossWidth-1] ^ den_w[DenWidth-1];
      csm_ff   <= csa_w[MagWidth-1:0];
      denm_ff  <= dena_w[MagWidth-1:0];
      mx_ff    <= ddx3_ff[DiffWidth-1] ? DiffWidth'(-ddx3_ff) : DiffWidth'(ddx3_ff);
      my_ff    <= ddy3_ff[DiffWidth-1] ? DiffWidth'(-ddy3_ff) : DiffWidth'(ddy3_ff);
      nx_ff    <= ddx3_ff[DiffWidth-1];
      ny_ff    <= ddy3_ff[DiffWidth-1];
      sx4_ff <= sx3_ff; sy4_ff <= sy3_ff;

      o_ff.hit  <= hit4_ff;
      o_ff.sx   <= sx4_ff;
      o_ff.sy   <= sy4_ff;
      o_ff.negx <= nx_ff ^ sneg4_ff;
      o_ff.negy <= ny_ff ^ sneg4_ff;
      o_ff.numx <= NumWidth'(mx_ff) * NumWidth'(csm_ff);
      o_ff.numy <= NumWidth'(my_ff) * NumWidth'(csm_ff);
      o_ff.den  <= denm_ff;
   end

   assign out = o_ff;
endmodule
`default_nettype wire

FILE: rtl/sli_divider.sv
`default_nettype none
module sli_divider import sli_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  div_in_type      in,
   output logic            out_valid,
   output logic            out_hit,
   output coord_type       out_x,
   output coord_type       out_y
);
   // One quotient bit per stage; the quotient is below 2^QuoWidth since |t| <= 1.
   localparam int Stages = QuoWidth;
   localparam int RemWidth = MagWidth + 1;

   div_in_type st_ff [Stages+1];
   logic [RemWidth-1:0] rx_ff [Stages+1];
   logic [RemWidth-1:0] ry_ff [Stages+1];
   logic [QuoWidth-1:0] qx_ff [Stages+1];
   logic [QuoWidth-1:0] qy_ff [Stages+1];
   logic v_ff, h_ff;
   coord_type x_ff, y_ff;

   // Seed: numerator is below den * 2^QuoWidth, so its top bits form a remainder below den.
   always_comb begin
      st_ff[0] = in;
      rx_ff[0] = RemWidth'(in.numx >> QuoWidth);
      ry_ff[0] = RemWidth'(in.numy >> QuoWidth);
      qx_ff[0] = '0;
      qy_ff[0] = '0;
   end

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      localparam int Bit = Stages - 1 - g;
      logic [RemWidth-1:0] tx_w, ty_w;
      always_comb begin
         tx_w = {rx_ff[g][MagWidth-1:0], st_ff[g].numx[Bit]};
         ty_w = {ry_ff[g][MagWidth-1:0], st_ff[g].numy[Bit]};
      end
      always_ff @(posedge clock) begin
         if (reset) st_ff[g+1].valid <= 1'b0;
         else       st_ff[g+1].valid <= st_ff[g].valid;
         st_ff[g+1].hit  <= st_ff[g].hit;
         st_ff[g+1].sx   <= st_ff[g].sx;
         st_ff[g+1].sy   <= st_ff[g].sy;
         st_ff[g+1].negx <= st_ff[g].negx;
         st_ff[g+1].negy <= st_ff[g].negy;
         st_ff[g+1].numx <= st_ff[g].numx;
         st_ff[g+1].numy <= st_ff[g].numy;
         st_ff[g+1].den  <= st_ff[g].den;
         if (tx_w >= RemWidth'(st_ff[g].den)) begin
            rx_ff[g+1] <= tx_w - RemWidth'(st_ff[g].den);
            qx_ff[g+1] <= qx_ff[g] | QuoWidth'(1 << Bit);
         end else begin
            rx_ff[g+1] <= tx_w;
            qx_ff[g+1] <= qx_ff[g];
         end
         if (ty_w >= RemWidth'(st_ff[g].den)) begin
            ry_ff[g+1] <= ty_w - RemWidth'(st_ff[g].den);
            qy_ff[g+1] <= qy_ff[g] | QuoWidth'(1 << Bit);
         end else begin
            ry_ff[g+1] <= ty_w;
            qy_ff[g+1] <= qy_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= st_ff[Stages].valid;
      h_ff <= st_ff[Stages].hit;
      if (!st_ff[Stages].hit) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= st_ff[Stages].negx ? st_ff[Stages].sx - CoordWidth'(qx_ff[Stages])
                                    : st_ff[Stages].sx + CoordWidth'(qx_ff[Stages]);
         y_ff <= st_ff[Stages].negy ? st_ff[Stages].sy - CoordWidth'(qy_ff[Stages])
                                    : st_ff[Stages].sy + CoordWidth'(qy_ff[Stages]);
      end
   end

   assign out_valid = v_ff;
   assign out_hit   = h_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

`ifndef SYNTHESIS
   a_quo_x_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff[Stages].valid && st_ff[Stages].hit |-> rx_ff[Stages] < RemWidth'(st_ff[Stages].den))
      else $error("x remainder not below divisor");
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      v_ff && !h_ff |-> x_ff == '0 && y_ff == '0)
      else $error("miss result carries a point");
   a_hit_den: assert property (@(posedge clock) disable iff (reset)
      st_ff[Stages].valid && st_ff[Stages].hit |-> st_ff[Stages].den != '0)
      else $error("hit with zero denominator");
`endif
endmodule
`default_nettype wire

FILE: rtl/segment_line_intersection_unit.sv
`default_nettype none
// rsp_valid rises once an accepted start has passed through every register stage
// and stays up for one cycle.
// Throughput: one item per cycle; busy is never raised, the pipeline always advances.
// The pipeline has 23 register stages: 5 arithmetic stages in the front end,
// 17 divider stages with one quotient bit each, and the output register.
// Reset (synchronous, active high) clears every valid bit; no result comes out after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module segment_line_intersection_unit import sli_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire coord_type req_seg_start_x,
   input  wire coord_type req_seg_start_y,
   input  wire coord_type req_seg_end_x,
   input  wire coord_type req_seg_end_y,
   input  wire coord_type req_line_a_x,
   input  wire coord_type req_line_a_y,
   input  wire coord_type req_line_b_x,
   input  wire coord_type req_line_b_y,
   output logic           rsp_valid,
   output logic           rsp_hit,
   output coord_type      rsp_cross_x,
   output coord_type      rsp_cross_y
);
   div_in_type div_in;

   // Nothing ever holds the pipeline, so an item is accepted on every start.
   assign busy = 1'b0;

   // Cross products, hit test and interpolation numerators.
   sli_front u_front (
      .clock, .reset, .in_valid(start),
      .sx(req_seg_start_x), .sy(req_seg_start_y),
      .ex(req_seg_end_x), .ey(req_seg_end_y),
      .ax(req_line_a_x), .ay(req_line_a_y),
      .bx(req_line_b_x), .by(req_line_b_y),
      .out(div_in)
   );

   // Pipelined restoring divider and final offset from the segment start.
   sli_divider u_div (
      .clock, .reset, .in(div_in),
      .out_valid(rsp_valid), .out_hit(rsp_hit),
      .out_x(rsp_cross_x), .out_y(rsp_cross_y)
   );
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench import sli_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 40;

   // One expected crossing result.
   typedef struct {
      logic      hit;
      coord_type cross_x;
      coord_type cross_y;
   } crossing_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_seg_start_x = '0;
   coord_type req_seg_start_y = '0;
   coord_type req_seg_end_x   = '0;
   coord_type req_seg_end_y   = '0;
   coord_type req_line_a_x    = '0;
   coord_type req_line_a_y    = '0;
   coord_type req_line_b_x    = '0;
   coord_type req_line_b_y    = '0;
   logic      rsp_valid;
   logic      rsp_hit;
   coord_type rsp_cross_x;
   coord_type rsp_cross_y;

   crossing_type pending_crossings[$];
   int           error_count  = 0;
   int           items_sent   = 0;
   int           results_seen = 0;
   int           hits_seen    = 0;
   int           idle_cycles  = 0;
   int           burst_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   segment_line_intersection_unit DUT (
      .clock, .reset, .start, .busy,
      .req_seg_start_x, .req_seg_start_y, .req_seg_end_x, .req_seg_end_y,
      .req_line_a_x, .req_line_a_y, .req_line_b_x, .req_line_b_y,
      .rsp_valid, .rsp_hit, .rsp_cross_x, .rsp_cross_y
   );

   // Interpolates one coordinate: origin + trunc(delta * cs / den). Plain
   // signed 64-bit arithmetic is exact here: |delta| < 2^17 and |cs| < 2^35,
   // so the product stays below 2^52. SystemVerilog division truncates toward
   // zero, which is the rounding the block uses.
   function automatic coord_type interpolate(longint origin, longint delta,
                                             longint cs, longint den);
      longint offset;
      offset = (delta * cs) / den;
      return coord_type'(origin + offset);
   endfunction

   // Predicts where the line through A and B crosses the segment S->E.
   // The cross products of the line direction with the offsets of both
   // endpoints give the crossing fraction; their signs tell if it is in range.
   function automatic crossing_type predict_crossing(
         coord_type sx, coord_type sy, coord_type ex, coord_type ey,
         coord_type ax, coord_type ay, coord_type bx, coord_type by);
      crossing_type r;
      longint dx, dy, cs, ce, den;
      dx  = longint'(bx) - longint'(ax);
      dy  = longint'(by) - longint'(ay);
      cs  = dx * (longint'(sy) - ay) - dy * (longint'(sx) - ax);
      ce  = dx * (longint'(ey) - ay) - dy * (longint'(ex) - ax);
      den = cs - ce;
      r.hit     = 1'b0;
      r.cross_x = '0;
      r.cross_y = '0;
      // A zero denominator means a parallel, collinear or degenerate setup.
      if (den == 0) return r;
      // Either endpoint on the line is a hit; otherwise the signs must differ.
      if (cs != 0 && ce != 0 && ((cs < 0) == (ce < 0))) return r;
      r.hit     = 1'b1;
      r.cross_x = interpolate(sx, longint'(ex) - sx, cs, den);
      r.cross_y = interpolate(sy, longint'(ey) - sy, cs, den);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Sends one item. Between most bursts the sender pauses at random, so
   // gaps land on every phase of the pipeline. Start is lowered only when a
   // gap begins, so it changes at most once per clock edge.
   task automatic send_item(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                            coord_type ax, coord_type ay, coord_type bx, coord_type by);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      pending_crossings.push_back(predict_crossing(sx, sy, ex, ey, ax, ay, bx, by));
      start           <= 1'b1;
      req_seg_start_x <= sx;
      req_seg_start_y <= sy;
      req_seg_end_x   <= ex;
      req_seg_end_y   <= ey;
      req_line_a_x    <= ax;
      req_line_a_y    <= ay;
      req_line_b_x    <= bx;
      req_line_b_y    <= by;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 3) == 0 ? 16'sh8000 : 16'sh7fff);
         1: return coord_type'($signed($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Results are sampled at the rising edge that ends their strobe cycle.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_hit) hits_seen++;
         if (pending_crossings.size() == 0) begin
            error_count++;
            $display("UNEXPECTED result at %0t", $realtime);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_cross_x !== want.cross_x)
               report_mismatch("cross_x", rsp_cross_x, want.cross_x);
            if (rsp_cross_y !== want.cross_y)
               report_mismatch("cross_y", rsp_cross_y, want.cross_y);
         end
      end
   end

   // Watchdog: counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired with %0d results outstanding",
                  pending_crossings.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Extremes of every field, plus the named special cases.
   task automatic test_directed();
      // Zero denominator: parallel line, collinear segment, degenerate line
      // and degenerate segment.
      send_item(0, 0, 160, 0, 0, 16, 160, 16);
      send_item(0, 0, 160, 0, -32, 0, 320, 0);
      send_item(0, -16, 0, 16, 48, 48, 48, 48);
      send_item(32, 32, 32, 32, 0, 0, 16, 16);
      // Start on the line, end on the line.
      send_item(0, 0, 160, 160, 0, 0, 16, -16);
      send_item(-160, 0, 160, 0, 160, -5, 160, 7);
      // Plain crossing and a crossing beyond the segment.
      send_item(0, 0, 160, 160, 0, 160, 160, 0);
      send_item(0, 0, 16, 16, 0, 160, 160, 144);
      // Truncation toward zero on both signs.
      send_item(0, 0, 7, -7, 3, -100, 4, 100);
      send_item(0, 0, -7, 7, -3, -100, -4, 100);
      // Full-range extremes.
      send_item(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_item(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7ffe);
      send_item(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh7fff, 0, 16'sh8000, 1);
      send_item(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_item(-1, -1, -1, -1, -1, -1, -1, -1);
      send_item(0, 0, 0, 0, 0, 0, 0, 0);
   endtask

   // Random queries. Most draw the line through a point near the segment
   // midpoint so that hits are common; the rest are unconstrained coordinates.
   task automatic test_random(int count);
      coord_type sx, sy, ex, ey, ax, ay, bx, by;
      for (int i = 0; i < count; i++) begin
         sx = random_coord(); sy = random_coord();
         ex = random_coord(); ey = random_coord();
         if ($urandom_range(0, 3) != 0) begin
            // Line through a point near the segment midpoint, random slope.
            ax = coord_type'((longint'(sx) + ex) / 2 + $signed($urandom_range(0, 32)) - 16);
            ay = coord_type'((longint'(sy) + ey) / 2 + $signed($urandom_range(0, 32)) - 16);
            bx = coord_type'($urandom);
            by = coord_type'($urandom);
         end else begin
            ax = random_coord(); ay = random_coord();
            bx = random_coord(); by = random_coord();
         end
         send_item(sx, sy, ex, ey, ax, ay, bx, by);
      end
   endtask

   initial begin
      int drain_wait;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(900);
      start <= 1'b0;
      // Wait for the pipeline to empty, then a little longer for strays.
      drain_wait = 0;
      while (pending_crossings.size() != 0 && drain_wait < WatchdogLimit) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d segment/line queries; %0d results checked, %0d of them hits.",
               items_sent, results_seen, hits_seen);
      if (error_count == 0 && pending_crossings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  error_count, pending_crossings.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/sli_pkg.sv
rtl/sli_front.sv
rtl/sli_divider.sv
rtl/segment_line_intersection_unit.sv
tb/testbench.sv
